// ===== sv/union_find_diameter_merge_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Union-find diameter merge unit: assertion macros
// Shared property macros for the checkers of the merge unit.
// ---------------------------------------------------------------------------
`ifndef UNION_FIND_DIAMETER_MERGE_UNIT_DEFINES_SVH
`define UNION_FIND_DIAMETER_MERGE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UFDM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ufdm check failed");

// Consequent must hold in the cycle after the antecedent.
`define UFDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ufdm check failed");

`endif

// ===== sv/ufdm_pkg.sv =====
// ---------------------------------------------------------------------------
// Union-find diameter merge package
// Field widths, operation codes, shared structs and the diameter merge rule.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ufdm_pkg;

   localparam int NODES_DEF    = 1024;
   localparam int NODE_FIELD_W = 10;
   localparam int DIAM_W       = 10;
   localparam int RANK_W       = 4;
   localparam int OP_W         = 2;
   localparam int DIAM_MAX     = (1 << DIAM_W) - 1;
   localparam int RANK_MAX     = (1 << RANK_W) - 1;

   typedef enum logic [OP_W-1:0] {
      OP_QUERY = 2'd0,
      OP_MERGE = 2'd1,
      OP_LINK  = 2'd2,
      OP_SET   = 2'd3
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [NODE_FIELD_W-1:0] node_a;
      logic [NODE_FIELD_W-1:0] node_b;
      logic [DIAM_W-1:0]       set_value;
      logic                    in_range;
   } req_type;

   typedef struct packed {
      logic [DIAM_W-1:0] diameter;
      logic              already_joined;
   } rsp_type;

   typedef struct packed {
      logic    start;
      logic    take;
      req_type req;
   } ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } status_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [DIAM_W-1:0] diam;
   } info_type;

   function automatic logic [DIAM_W-1:0] merge_diameter(input logic [DIAM_W-1:0] da,
                                                        input logic [DIAM_W-1:0] db);
      logic [DIAM_W:0]   ha;
      logic [DIAM_W:0]   hb;
      logic [DIAM_W+1:0] m;
      ha = ((DIAM_W+1)'(da) + (DIAM_W+1)'(1)) >> 1;
      hb = ((DIAM_W+1)'(db) + (DIAM_W+1)'(1)) >> 1;
      m  = (DIAM_W+2)'(ha) + (DIAM_W+2)'(hb) + (DIAM_W+2)'(1);
      if ((DIAM_W+2)'(da) > m) begin
         m = (DIAM_W+2)'(da);
      end
      if ((DIAM_W+2)'(db) > m) begin
         m = (DIAM_W+2)'(db);
      end
      if (m > (DIAM_W+2)'(DIAM_MAX)) begin
         m = (DIAM_W+2)'(DIAM_MAX);
      end
      return m[DIAM_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/union_find_diameter_merge_unit.sv =====
// ---------------------------------------------------------------------------
// Union-find diameter merge unit
// Disjoint-set engine with union by rank, full path compression and a
// diameter kept at each set root. After reset the unit initializes every
// entry of its parent and rank/diameter memories and holds req_stall
// high meanwhile. It then handles one request at a time. How long a
// request takes grows with Pa for a one-node operation and with Pa and Pb
// for merge and link, where Pa and Pb are the parent chain lengths of the
// named nodes; the single read port of the parent memory sets this, since
// the find walk and the compression walk each take one parent read per
// cycle. Path compression keeps chains short. A result waits in an output
// register so the next request is taken while it is still stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module union_find_diameter_merge_unit #(
   parameter int NODES = ufdm_pkg::NODES_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire [ufdm_pkg::OP_W-1:0]           req_op,
   input  wire [ufdm_pkg::NODE_FIELD_W-1:0]   req_node_a,
   input  wire [ufdm_pkg::NODE_FIELD_W-1:0]   req_node_b,
   input  wire [ufdm_pkg::DIAM_W-1:0]         req_set_value,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [ufdm_pkg::DIAM_W-1:0]        rsp_diameter,
   output logic                               rsp_already_joined
);
   import ufdm_pkg::*;

   ctl_type    ctl;
   status_type stat;
   rsp_type    core_rsp;
   op_type     op;
   logic       two_node;
   logic       a_ok;
   logic       b_ok;

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   assign op       = op_type'(req_op);
   assign two_node = (op == OP_MERGE) || (op == OP_LINK);
   assign a_ok     = 32'(req_node_a) < 32'(NODES);
   assign b_ok     = 32'(req_node_b) < 32'(NODES);

   assign req_stall = !stat.idle;

   assign ctl.start         = req_valid && !req_stall;
   assign ctl.take          = stat.done && (!rsp_valid_ff || !rsp_stall);
   assign ctl.req.op        = op;
   assign ctl.req.node_a    = req_node_a;
   assign ctl.req.node_b    = req_node_b;
   assign ctl.req.set_value = req_set_value;
   assign ctl.req.in_range  = a_ok && (!two_node || b_ok);

   ufdm_core #(
      .NODES(NODES)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .ctl_i (ctl),
      .stat_o(stat),
      .rsp_o (core_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (ctl.take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_diameter       = rsp_ff.diameter;
   assign rsp_already_joined = rsp_ff.already_joined;

endmodule

`default_nettype wire

// ===== sv/ufdm_core.sv =====
// ---------------------------------------------------------------------------
// Union-find diameter merge core
// Parent memory and rank/diameter memory with the find, compression and
// union sequencer that reads, modifies and writes them back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufdm_core #(
   parameter int NODES = ufdm_pkg::NODES_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire ufdm_pkg::ctl_type ctl_i,
   output ufdm_pkg::status_type  stat_o,
   output ufdm_pkg::rsp_type     rsp_o
);
   import ufdm_pkg::*;

   localparam int NODE_W = $clog2(NODES);
   localparam int EXT_W  = (NODE_W > NODE_FIELD_W) ? NODE_W : NODE_FIELD_W;
   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_FIND  = 8'b0000_0100,
      ST_COMP  = 8'b0000_1000,
      ST_RDA   = 8'b0001_0000,
      ST_RDB   = 8'b0010_0000,
      ST_EXEC  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [NODE_W-1:0]  clr_ff, clr_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   logic [NODE_W-1:0]  start_ff, start_in;
   logic [NODE_W-1:0]  root_ff, root_in;
   logic [NODE_W-1:0]  ra_ff, ra_in;
   logic [NODE_W-1:0]  rb_ff, rb_in;
   logic               phase_b_ff, phase_b_in;
   info_type           info_a_ff, info_a_in;
   logic [DIAM_W-1:0]  diam_ff, diam_in;
   logic               joined_ff, joined_in;

   logic [NODE_W-1:0]  par_mem [NODES];
   logic [NODE_W-1:0]  par_rdata_ff;
   logic [NODE_W-1:0]  par_raddr;
   logic               par_we;
   logic [NODE_W-1:0]  par_waddr;
   logic [NODE_W-1:0]  par_wdata;

   info_type           info_mem [NODES];
   info_type           inf_rdata_ff;
   logic [NODE_W-1:0]  inf_raddr;
   logic               inf_we;
   logic [NODE_W-1:0]  inf_waddr;
   info_type           inf_wdata;

   logic [EXT_W-1:0]   a_ext;
   logic [EXT_W-1:0]   b_ext;
   logic [NODE_W-1:0]  a_idx;
   logic [NODE_W-1:0]  b_idx;
   logic               two_node;
   info_type           info_b;
   info_type           win_info;
   logic [NODE_W-1:0]  win_node;
   logic [NODE_W-1:0]  lose_node;

   assign a_ext    = EXT_W'(ctl_i.req.node_a);
   assign b_ext    = EXT_W'(req_ff.node_b);
   assign a_idx    = a_ext[NODE_W-1:0];
   assign b_idx    = b_ext[NODE_W-1:0];
   assign two_node = (req_ff.op == OP_MERGE) || (req_ff.op == OP_LINK);
   assign info_b   = inf_rdata_ff;

   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem[par_waddr] <= par_wdata;
      end
      par_rdata_ff <= par_mem[par_raddr];
   end

   always_ff @(posedge clock) begin
      if (inf_we) begin
         info_mem[inf_waddr] <= inf_wdata;
      end
      inf_rdata_ff <= info_mem[inf_raddr];
   end

   always_comb begin
      if (info_a_ff.rank > info_b.rank) begin
         win_node  = ra_ff;
         lose_node = rb_ff;
         win_info  = info_a_ff;
      end else if (info_a_ff.rank < info_b.rank) begin
         win_node  = rb_ff;
         lose_node = ra_ff;
         win_info  = info_b;
      end else begin
         win_node  = ra_ff;
         lose_node = rb_ff;
         win_info  = info_a_ff;
         if (info_a_ff.rank != RANK_W'(RANK_MAX)) begin
            win_info.rank = info_a_ff.rank + RANK_W'(1);
         end
      end
      if (req_ff.op == OP_MERGE) begin
         win_info.diam = merge_diameter(info_a_ff.diam, info_b.diam);
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      clr_in     = clr_ff;
      cur_in     = cur_ff;
      start_in   = start_ff;
      root_in    = root_ff;
      ra_in      = ra_ff;
      rb_in      = rb_ff;
      phase_b_in = phase_b_ff;
      info_a_in  = info_a_ff;
      diam_in    = diam_ff;
      joined_in  = joined_ff;
      par_raddr  = cur_ff;
      par_we     = 1'b0;
      par_waddr  = cur_ff;
      par_wdata  = root_ff;
      inf_raddr  = ra_ff;
      inf_we     = 1'b0;
      inf_waddr  = ra_ff;
      inf_wdata  = info_a_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            par_we    = 1'b1;
            par_waddr = clr_ff;
            par_wdata = clr_ff;
            inf_we    = 1'b1;
            inf_waddr = clr_ff;
            inf_wdata = '0;
            clr_in    = clr_ff + NODE_W'(1);
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (ctl_i.start) begin
               req_in     = ctl_i.req;
               diam_in    = '0;
               joined_in  = 1'b0;
               cur_in     = a_idx;
               start_in   = a_idx;
               phase_b_in = 1'b0;
               par_raddr  = a_idx;
               state_in   = ctl_i.req.in_range ? ST_FIND : ST_DONE;
            end
         end
         ST_FIND: begin
            if (par_rdata_ff == cur_ff) begin
               root_in   = cur_ff;
               cur_in    = start_ff;
               par_raddr = start_ff;
               state_in  = ST_COMP;
            end else begin
               cur_in    = par_rdata_ff;
               par_raddr = par_rdata_ff;
            end
         end
         ST_COMP: begin
            if (cur_ff == root_ff) begin
               if (phase_b_ff) begin
                  rb_in    = root_ff;
                  state_in = ST_RDA;
               end else begin
                  ra_in = root_ff;
                  if (two_node) begin
                     phase_b_in = 1'b1;
                     cur_in     = b_idx;
                     start_in   = b_idx;
                     par_raddr  = b_idx;
                     state_in   = ST_FIND;
                  end else begin
                     state_in = ST_RDA;
                  end
               end
            end else begin
               par_we    = 1'b1;
               par_waddr = cur_ff;
               par_wdata = root_ff;
               cur_in    = par_rdata_ff;
               par_raddr = par_rdata_ff;
            end
         end
         ST_RDA: begin
            inf_raddr = ra_ff;
            state_in  = ST_RDB;
         end
         ST_RDB: begin
            info_a_in = inf_rdata_ff;
            inf_raddr = rb_ff;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            unique case (req_ff.op)
               OP_QUERY: begin
                  diam_in = info_a_ff.diam;
               end
               OP_SET: begin
                  inf_we         = 1'b1;
                  inf_waddr      = ra_ff;
                  inf_wdata.rank = info_a_ff.rank;
                  inf_wdata.diam = req_ff.set_value;
                  diam_in        = req_ff.set_value;
               end
               OP_MERGE, OP_LINK: begin
                  if (ra_ff == rb_ff) begin
                     joined_in = 1'b1;
                     diam_in   = info_a_ff.diam;
                  end else begin
                     par_we    = 1'b1;
                     par_waddr = lose_node;
                     par_wdata = win_node;
                     inf_we    = 1'b1;
                     inf_waddr = win_node;
                     inf_wdata = win_info;
                     diam_in   = win_info.diam;
                  end
               end
               default: begin
                  diam_in = '0;
               end
            endcase
         end
         ST_DONE: begin
            if (ctl_i.take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      cur_ff     <= cur_in;
      start_ff   <= start_in;
      root_ff    <= root_in;
      ra_ff      <= ra_in;
      rb_ff      <= rb_in;
      phase_b_ff <= phase_b_in;
      info_a_ff  <= info_a_in;
      diam_ff    <= diam_in;
      joined_ff  <= joined_in;
   end

   assign stat_o.idle          = (state_ff == ST_IDLE);
   assign stat_o.done          = (state_ff == ST_DONE);
   assign rsp_o.diameter       = diam_ff;
   assign rsp_o.already_joined = joined_ff;

endmodule

`default_nettype wire

// ===== sv/ufdm_checker.sv =====
// ---------------------------------------------------------------------------
// Union-find diameter merge checker
// Port-level checks of the merge unit, bound to its top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "union_find_diameter_merge_unit_defines.svh"

module ufdm_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_valid,
   input wire                                req_stall,
   input wire                                rsp_valid,
   input wire                                rsp_stall,
   input wire [ufdm_pkg::DIAM_W-1:0]         rsp_diameter,
   input wire                                rsp_already_joined
);

   `UFDM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `UFDM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall,
                     $stable(rsp_diameter) && $stable(rsp_already_joined))
   `UFDM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `UFDM_ASSERT_SAME(a_init_sweep, clock, reset, $past(reset), req_stall)

endmodule

bind union_find_diameter_merge_unit ufdm_checker u_checker (.*);

`default_nettype wire
